// ===== design/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine package
// Shared widths, command and status codes, and the default capacity.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int DEFAULT_CAPACITY = 32;

    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_INSERT     = 3'd2,
        FN_DELETE     = 3'd3,
        FN_POP_FRONT  = 3'd4,
        FN_POP_BACK   = 3'd5,
        FN_CLEAR      = 3'd6,
        FN_COUNT      = 3'd7
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_RANGE    = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

endpackage

// ===== design/ordered_list_engine.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded double-ended list with positional insert, kept packed in a memory.
// ----------------------------------------------------------------------------
// Pop back, clear, count and every rejected request go straight from the
// idle state to the result state. A push or insert first moves the entries
// from its target on one place toward the back and then places the new value;
// pop front and delete first walk the list from the front. Since the input
// waits for the idle state, a new request is not taken until the last result
// has been loaded. Reset clears the count and control state, not the values.

module ordered_list_engine #(
    parameter int CAPACITY = ole_pkg::DEFAULT_CAPACITY
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ole_pkg::t_func              i_func,
    input  logic signed [ole_pkg::DATA_W-1:0] i_item_value,
    input  logic [ole_pkg::POS_W-1:0]   i_position,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ole_pkg::t_status            o_status,
    output logic [ole_pkg::COUNT_W-1:0] o_entry_count
);
    import ole_pkg::*;

    // Index width into the store and width of the entry count.
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    // Common width for the insert position range check.
    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    // The sequencer. WALK_R moves entries one place toward the back, starting
    // at the tail, and then drops the new value into the opened slot. WALK_L
    // reads entries from the front, compares each one against the search
    // value, and once a match is found (or forced, for pop front) copies each
    // following entry one place toward the front.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_WALK_L = 4'b0010,
        S_WALK_R = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state            r_state,    n_state;
    logic [CW-1:0]     r_count,    n_count;
    logic [CW-1:0]     r_rd_idx,   n_rd_idx;
    logic              r_rd_more,  n_rd_more;
    logic [CW-1:0]     r_data_idx, n_data_idx;
    logic              r_data_vld, n_data_vld;
    logic [CW-1:0]     r_tgt,      n_tgt;
    logic              r_found,    n_found;
    logic [DATA_W-1:0] r_val,      n_val;
    t_status           r_status,   n_status;
    logic              r_o_valid,  n_o_valid;
    t_status           r_o_status, n_o_status;
    logic [COUNT_W-1:0] r_o_count, n_o_count;

    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [DATA_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    logic [DATA_W-1:0] mem_rd_data;

    logic              is_full;
    logic              is_empty;
    logic [XW-1:0]     pos_x;
    logic [XW-1:0]     cnt_x;

    ole_store #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign is_full  = (r_count >= CW'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign pos_x    = XW'(i_position);
    assign cnt_x    = XW'(r_count);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_rd_more  = r_rd_more;
        n_data_idx = r_data_idx;
        n_data_vld = 1'b0;
        n_tgt      = r_tgt;
        n_found    = r_found;
        n_val      = r_val;
        n_status   = r_status;
        n_o_valid  = r_o_valid;
        n_o_status = r_o_status;
        n_o_count  = r_o_count;

        mem_wr_en   = 1'b0;
        mem_wr_addr = r_tgt[IW-1:0];
        mem_wr_data = r_val;
        mem_rd_en   = 1'b0;
        mem_rd_addr = r_rd_idx[IW-1:0];

        // The waiting result leaves once the consumer takes it.
        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_val     = i_item_value;
                    n_status  = ST_OK;
                    n_rd_more = 1'b0;
                    n_state   = S_DONE;
                    unique case (i_func)
                        FN_PUSH_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_tgt     = '0;
                                n_rd_idx  = r_count - CW'(1);
                                n_rd_more = !is_empty;
                                n_state   = S_WALK_R;
                            end
                        end
                        FN_PUSH_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_tgt   = r_count;
                                n_state = S_WALK_R;
                            end
                        end
                        FN_INSERT: begin
                            // Range is checked before fullness.
                            if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                                n_status = ST_RANGE;
                            end else if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_tgt     = CW'(pos_x - XW'(1));
                                n_rd_idx  = r_count - CW'(1);
                                n_rd_more = (cnt_x > pos_x - XW'(1));
                                n_state   = S_WALK_R;
                            end
                        end
                        FN_DELETE: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_rd_idx  = '0;
                                n_rd_more = 1'b1;
                                n_found   = 1'b0;
                                n_state   = S_WALK_L;
                            end
                        end
                        FN_POP_FRONT: begin
                            // Same walk as a delete whose match is the front.
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_rd_idx  = CW'(1);
                                n_rd_more = (r_count > CW'(1));
                                n_found   = 1'b1;
                                n_state   = S_WALK_L;
                            end
                        end
                        FN_POP_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        FN_COUNT: begin
                            n_count = r_count;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_WALK_L: begin
                if (r_rd_more) begin
                    mem_rd_en  = 1'b1;
                    n_rd_idx   = r_rd_idx + CW'(1);
                    n_rd_more  = ((r_rd_idx + CW'(1)) < r_count);
                    n_data_idx = r_rd_idx;
                    n_data_vld = 1'b1;
                end
                if (r_data_vld) begin
                    if (r_found) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = IW'(r_data_idx - CW'(1));
                        mem_wr_data = mem_rd_data;
                    end else if (mem_rd_data == r_val) begin
                        n_found = 1'b1;
                    end
                end
                if (!r_rd_more && !r_data_vld) begin
                    if (r_found) begin
                        n_count  = r_count - CW'(1);
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_NOTFOUND;
                    end
                    n_state = S_DONE;
                end
            end

            S_WALK_R: begin
                if (r_rd_more) begin
                    mem_rd_en  = 1'b1;
                    n_rd_idx   = r_rd_idx - CW'(1);
                    n_rd_more  = (r_rd_idx != r_tgt);
                    n_data_idx = r_rd_idx;
                    n_data_vld = 1'b1;
                end
                if (r_data_vld) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = IW'(r_data_idx + CW'(1));
                    mem_wr_data = mem_rd_data;
                end
                if (!r_rd_more && !r_data_vld) begin
                    // The slot at the target is open: place the new value.
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = r_tgt[IW-1:0];
                    mem_wr_data = r_val;
                    n_count     = r_count + CW'(1);
                    n_status    = ST_OK;
                    n_state     = S_DONE;
                end
            end

            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_count  = COUNT_W'(r_count);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_count    <= '0;
            r_rd_more  <= 1'b0;
            r_data_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_rd_more  <= n_rd_more;
            r_data_vld <= n_data_vld;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx   <= n_rd_idx;
        r_data_idx <= n_data_idx;
        r_tgt      <= n_tgt;
        r_found    <= n_found;
        r_val      <= n_val;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_count  <= n_o_count;
    end

    // New requests are taken only while the sequencer is idle.
    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_o_status;
    assign o_entry_count = r_o_count;

    // The count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // The store is only written while a walk is running.
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_DONE) |-> !mem_wr_en)
        else $error("store written outside a walk");

    // A fresh result only comes from the result state.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside the result state");

    // The count moves by one at a time, or drops to zero on a clear.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CW'(1) ||
             r_count == $past(r_count) - CW'(1) ||
             r_count == '0))
        else $error("count changed by more than one");

endmodule

// ===== design/ole_store.sv =====
// ----------------------------------------------------------------------------
// Ordered list entry store
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module ole_store #(
    parameter int DEPTH = ole_pkg::DEFAULT_CAPACITY,
    parameter int AW    = 5
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [AW-1:0]             i_wr_addr,
    input  logic [ole_pkg::DATA_W-1:0] i_wr_data,
    input  logic                      i_rd_en,
    input  logic [AW-1:0]             i_rd_addr,
    output logic [ole_pkg::DATA_W-1:0] o_rd_data
);
    import ole_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
